@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Clocked implications, disabled while the active-low reset is asserted; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/w3sf_pkg.sv @@
// Shared types and constants for the 3x3 dilation filter.
// No dependencies.
package w3sf_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 10;
    localparam int CFG_W     = 12;
    localparam int WIDTH_W   = 11;
    localparam int TDATA_W   = 32;
    localparam int TDATA_PAD = TDATA_W - PIX_W - ROW_W - COL_OUT_W;

    // Foreground pixel value
    localparam logic [PIX_W-1:0] FG = 8'hFF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

@@ rtl/core/w3sf_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module w3sf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/window3x3_saturate_filter.sv @@
// Top level of the streaming 3x3 dilation filter (255 is foreground).
// Depends on w3sf_pkg, w3sf_ram and assert_macros.svh.
//
// Usage:
//   s_axis carries one 8-bit pixel per beat in raster order. m_axis carries
//   one result per beat: dilated pixel, row and column, tlast on the last
//   result caused by an input pixel, tuser on the bottom-right pixel.
//   Width and height are written on the cfg port while the block is idle;
//   a write restarts the frame at row 0, column 0.
// Path: the results caused by a pixel leave on m_axis after it passes the input
//   stage (with the line-store read), the result group and the output register.
// Throughput: one pixel per clock while m_axis_tready is high. A pixel at a row
//   end causes two results and on the last row up to four; the result stage hands
//   out one result per cycle, so s_axis_tready drops there until they have left.
// Reset: counters and window clear, size returns to 640 x 480 (width at most
//   MAX_WIDTH). The line store is not cleared; rows 0 and 1 never look at stale entries.
// Stall: when m_axis_tready is low the output register holds, the result
//   stage and input stage fill, and s_axis_tready falls.
`include "assert_macros.svh"

module window3x3_saturate_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input pixels
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel_in
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] pixel_out, [19:8] out_row, [29:20] out_col, [31:30] zero
    output logic [w3sf_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,   // run_last
    output logic [0:0]                    m_axis_tuser,   // [0] frame_last
    // configuration
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [w3sf_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RST_LAST_COL = (MAX_WIDTH < 640) ? MAX_WIDTH - 1 : 639;
    localparam int PW = w3sf_pkg::PIX_W;
    localparam int RW = w3sf_pkg::ROW_W;
    localparam int OW = w3sf_pkg::COL_OUT_W;

    // frame geometry and position
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // input stage (waits for line-store read data)
    logic          r_a_valid;
    logic [PW-1:0] r_a_pix;
    logic [RW-1:0] r_a_row;
    logic [CW-1:0] r_a_col;
    logic          r_a_row_end;
    logic          r_a_last_row;

    // 3x3 window, [row][col], column 2 newest
    logic [PW-1:0] r_win [3][3];
    logic [PW-1:0] n_win [3][3];

    // result group: up to four slots per input pixel
    logic [3:0]    r_b_pend;
    logic [PW-1:0] r_b_pix [4];
    logic [RW-1:0] r_b_row [4];
    logic [OW-1:0] r_b_col [4];

    // output register
    logic          r_o_valid;
    logic [PW-1:0] r_o_pix;
    logic [RW-1:0] r_o_row;
    logic [OW-1:0] r_o_col;
    logic          r_o_last;
    logic          r_o_fl;

    logic              accept;
    logic              a_move;
    logic              b_free;
    logic              out_load;
    logic [1:0]        sel;
    logic [3:0]        sel_mask;
    logic [2*PW-1:0]   ram_rdata;
    logic [2*PW-1:0]   ram_wdata;
    logic [PW-1:0]     up_pix;
    logic [PW-1:0]     lo_pix;
    logic [3:0]        slot_ok;
    logic [3:0]        slot_fg;
    logic              f [3][3];
    logic              core_fg;
    logic              rg2;
    logic              cg2;
    logic [RW-1:0]     row_m1;
    logic [CW-1:0]     col_m1;
    logic [w3sf_pkg::WIDTH_W-1:0] cfg_w;
    logic [CW-1:0]     n_last_col;
    logic [RW-1:0]     n_last_row;

    // handshake
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_b_pend != 4'd0) && (!r_o_valid || m_axis_tready);
    assign b_free   = (r_b_pend == 4'd0) || ($onehot(r_b_pend) && out_load);
    assign a_move   = r_a_valid && b_free;
    assign s_axis_tready = i_rst_n && (!r_a_valid || a_move);

    // line store: [7:0] upper row, [15:8] lower row
    assign up_pix    = ram_rdata[PW-1:0];
    assign lo_pix    = ram_rdata[2*PW-1:PW];
    assign ram_wdata = {r_a_pix, lo_pix};

    w3sf_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (a_move),
        .i_waddr (r_a_col),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // clamped geometry from a config write
    assign cfg_w = i_cfg_data[w3sf_pkg::WIDTH_W-1:0];
    always_comb begin
        if (cfg_w < 11'd2) begin
            n_last_col = CW'(1);
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            n_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            n_last_col = CW'(cfg_w - 11'd1);
        end
        if (i_cfg_data < 12'd2) begin
            n_last_row = RW'(1);
        end else begin
            n_last_row = i_cfg_data - 12'd1;
        end
    end

    // geometry registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_LAST_COL);
            r_last_row <= RW'(479);
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_we) begin
            unique case (w3sf_pkg::t_cfg_reg'(i_cfg_addr))
                w3sf_pkg::CFG_WIDTH:  r_last_col <= n_last_col;
                w3sf_pkg::CFG_HEIGHT: r_last_row <= n_last_row;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix      <= s_axis_tdata;
            r_a_row      <= r_row;
            r_a_col      <= r_col;
            r_a_row_end  <= (r_col == r_last_col);
            r_a_last_row <= (r_row == r_last_row);
        end
    end

    // window shift with the new column from the line store
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = up_pix;
        n_win[1][2] = lo_pix;
        n_win[2][2] = r_a_pix;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                f[i][j] = (n_win[i][j] == w3sf_pkg::FG);
            end
        end
    end

    // clipped neighborhoods of the up to four results
    assign rg2     = (r_a_row >= RW'(2));
    assign cg2     = (r_a_col >= CW'(2));
    assign core_fg = f[1][1] | f[1][2] | f[2][1] | f[2][2];
    assign slot_fg[0] = core_fg | (cg2 & (f[1][0] | f[2][0]))
                      | (rg2 & (f[0][1] | f[0][2])) | (rg2 & cg2 & f[0][0]);
    assign slot_fg[1] = core_fg | (rg2 & (f[0][1] | f[0][2]));
    assign slot_fg[2] = core_fg | (cg2 & (f[1][0] | f[2][0]));
    assign slot_fg[3] = core_fg;

    assign slot_ok[0] = (r_a_row != '0) && (r_a_col != '0);
    assign slot_ok[1] = slot_ok[0] && r_a_row_end;
    assign slot_ok[2] = slot_ok[0] && r_a_last_row;
    assign slot_ok[3] = slot_ok[2] && r_a_row_end;

    assign row_m1 = r_a_row - RW'(1);
    assign col_m1 = r_a_col - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (a_move) begin
            r_win <= n_win;
        end
    end

    // result group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_pend <= 4'd0;
        end else if (a_move) begin
            r_b_pend <= slot_ok;
        end else if (out_load) begin
            r_b_pend <= r_b_pend & ~sel_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_pix[0] <= slot_fg[0] ? w3sf_pkg::FG : n_win[1][1];
            r_b_pix[1] <= slot_fg[1] ? w3sf_pkg::FG : n_win[1][2];
            r_b_pix[2] <= slot_fg[2] ? w3sf_pkg::FG : n_win[2][1];
            r_b_pix[3] <= slot_fg[3] ? w3sf_pkg::FG : n_win[2][2];
            r_b_row[0] <= row_m1;
            r_b_row[1] <= row_m1;
            r_b_row[2] <= r_a_row;
            r_b_row[3] <= r_a_row;
            r_b_col[0] <= OW'(col_m1);
            r_b_col[1] <= OW'(r_a_col);
            r_b_col[2] <= OW'(col_m1);
            r_b_col[3] <= OW'(r_a_col);
        end
    end

    // lowest pending slot goes out first
    always_comb begin
        sel = 2'd0;
        for (int k = 3; k >= 0; k--) begin
            if (r_b_pend[k]) begin
                sel = 2'(k);
            end
        end
        sel_mask = 4'b0001 << sel;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_pix  <= r_b_pix[sel];
            r_o_row  <= r_b_row[sel];
            r_o_col  <= r_b_col[sel];
            r_o_last <= $onehot(r_b_pend);
            r_o_fl   <= (sel == 2'd3);
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = {{w3sf_pkg::TDATA_PAD{1'b0}}, r_o_col, r_o_row, r_o_pix};
    assign m_axis_tlast    = r_o_last;
    assign m_axis_tuser[0] = r_o_fl;

    // checks
    `ASSERT_IMP(a_stage_drains, i_clk, i_rst_n, r_a_valid && (r_b_pend == 4'd0), a_move)
    `ASSERT_IMP(frame_end_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    `ASSERT_IMP(no_ram_collision, i_clk, i_rst_n, a_move && accept, r_a_col != r_col)
    `ASSERT_NXT(accept_fills_a, i_clk, i_rst_n, accept, r_a_valid)

endmodule

@@ verif/w3sf_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the 3x3 dilation filter: watches the pixel, result and config ports,
// predicts every result in order and compares it field by field. Depends on w3sf_pkg.
module w3sf_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel channel
    input  logic                                 i_pix_valid,
    input  logic                                 i_pix_ready,
    input  logic [7:0]                           i_pix_data,    // [7:0] pixel_in
    // result channel
    input  logic                                 i_res_valid,
    input  logic                                 i_res_ready,
    // [7:0] pixel_out, [19:8] out_row, [29:20] out_col, [31:30] zero
    input  logic [w3sf_pkg::TDATA_W-1:0]         i_res_data,
    input  logic                                 i_res_last,    // run_last
    input  logic [0:0]                           i_res_user,    // [0] frame_last
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_addr,
    input  logic [w3sf_pkg::CFG_W-1:0]           i_cfg_data,
    output int                                   o_mismatches,
    output int                                   o_pending
);

    typedef struct packed {
        logic [w3sf_pkg::PIX_W-1:0]     pixel;
        logic [w3sf_pkg::ROW_W-1:0]     row;
        logic [w3sf_pkg::COL_OUT_W-1:0] col;
        logic                           run_last;
        logic                           frame_last;
    } t_dilated_pix;

    t_dilated_pix       dilated_q [$];

    // predictor state
    logic [w3sf_pkg::PIX_W-1:0]   upper_line [MAX_WIDTH];
    logic [w3sf_pkg::PIX_W-1:0]   lower_line [MAX_WIDTH];
    logic [w3sf_pkg::PIX_W-1:0]   win [3][3];
    int unsigned                  row_cnt;
    int unsigned                  col_cnt;
    logic [w3sf_pkg::WIDTH_W-1:0] width_reg;
    logic [w3sf_pkg::ROW_W-1:0]   height_reg;
    int                           mismatches = 0;

    // FG if any window pixel from row r0 and column c0 onward is FG, else the center value
    function automatic logic [w3sf_pkg::PIX_W-1:0] dilate_at(int r0, int c0,
                                                            logic [w3sf_pkg::PIX_W-1:0] center);
        int i;
        int j;
        for (i = r0; i <= 2; i++)
            for (j = c0; j <= 2; j++)
                if (win[i][j] == w3sf_pkg::FG) return w3sf_pkg::FG;
        return center;
    endfunction

    function automatic t_dilated_pix make_result(logic [w3sf_pkg::PIX_W-1:0] value,
                                                 int unsigned row, int unsigned col,
                                                 bit frame_end);
        t_dilated_pix res;
        res.pixel      = value;
        res.row        = row[w3sf_pkg::ROW_W-1:0];
        res.col        = col[w3sf_pkg::COL_OUT_W-1:0];
        res.run_last   = 1'b0;
        res.frame_last = frame_end;
        return res;
    endfunction

    // One accepted pixel: shift line stores and window, queue the results it completes
    task automatic predict_dilation(input logic [w3sf_pkg::PIX_W-1:0] pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int           r0;
        int           c0;
        int           n;
        int           i;
        logic [w3sf_pkg::PIX_W-1:0] up;
        logic [w3sf_pkg::PIX_W-1:0] lo;
        bit           row_end;
        bit           last_row;
        t_dilated_pix batch [4];

        w = width_reg;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (height_reg < 2) ? 2 : height_reg;
        r = row_cnt;
        c = col_cnt;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;

        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = pix;
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = pix;

        row_end  = (c == w - 1);
        last_row = (r == h - 1);
        // top row and left column have a clipped window
        r0 = (r >= 2) ? 0 : 1;
        c0 = (c >= 2) ? 0 : 1;

        n = 0;
        if (r >= 1 && c >= 1) begin
            batch[n] = make_result(dilate_at(r0, c0, win[1][1]), r - 1, c - 1, 1'b0);
            n++;
            if (row_end) begin
                batch[n] = make_result(dilate_at(r0, 1, win[1][2]), r - 1, c, 1'b0);
                n++;
            end
            // last row is finished right away, there is no row below it
            if (last_row) begin
                batch[n] = make_result(dilate_at(1, c0, win[2][1]), r, c - 1, 1'b0);
                n++;
                if (row_end) begin
                    batch[n] = make_result(dilate_at(1, 1, win[2][2]), r, c, 1'b1);
                    n++;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            batch[i].run_last = (i == n - 1);
            dilated_q.push_back(batch[i]);
        end

        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    task automatic check_result();
        t_dilated_pix                   want;
        logic [w3sf_pkg::PIX_W-1:0]     got_pix;
        logic [w3sf_pkg::ROW_W-1:0]     got_row;
        logic [w3sf_pkg::COL_OUT_W-1:0] got_col;
        logic [w3sf_pkg::TDATA_PAD-1:0] got_pad;

        got_pix = i_res_data[w3sf_pkg::PIX_W-1:0];
        got_row = i_res_data[w3sf_pkg::PIX_W +: w3sf_pkg::ROW_W];
        got_col = i_res_data[w3sf_pkg::PIX_W+w3sf_pkg::ROW_W +: w3sf_pkg::COL_OUT_W];
        got_pad = i_res_data[w3sf_pkg::TDATA_W-1 -: w3sf_pkg::TDATA_PAD];
        if (dilated_q.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected beat: pixel %0d row %0d col %0d", $realtime,
                         got_pix, got_row, got_col);
            mismatches++;
        end else begin
            want = dilated_q.pop_front();
            if (got_pix !== want.pixel || got_row !== want.row || got_col !== want.col ||
                got_pad !== '0 || i_res_last !== want.run_last ||
                i_res_user[0] !== want.frame_last) begin
                if (mismatches < 10)
                    $display({"%0t: pix/row/col/pad/last/user ",
                              "exp %0d/%0d/%0d/0/%0b/%0b got %0d/%0d/%0d/%0d/%0b/%0b"},
                             $realtime, want.pixel, want.row, want.col, want.run_last,
                             want.frame_last, got_pix, got_row, got_col, got_pad, i_res_last,
                             i_res_user[0]);
                mismatches++;
            end
        end
    endtask

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 11'd640;
            height_reg = 12'd480;
            row_cnt    = 0;
            col_cnt    = 0;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                upper_line[k] = '0;
                lower_line[k] = '0;
            end
            for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
            dilated_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            // a write restarts the frame, stores and window are kept
            if (i_cfg_we) begin
                if (i_cfg_addr == w3sf_pkg::CFG_WIDTH)
                    width_reg = i_cfg_data[w3sf_pkg::WIDTH_W-1:0];
                else
                    height_reg = i_cfg_data[w3sf_pkg::ROW_W-1:0];
                row_cnt = 0;
                col_cnt = 0;
            end
            if (i_pix_valid && i_pix_ready) predict_dilation(i_pix_data);
        end
        o_pending    = dilated_q.size();
        o_mismatches = mismatches;
    end

endmodule

@@ verif/tb_window3x3_saturate_filter.sv @@
`timescale 1ns / 1ps
// Top of the 3x3 dilation filter testbench: clock, reset, pixel and config stimulus,
// random backpressure and the verdict. Depends on w3sf_pkg, the RTL and w3sf_checker.
module tb_window3x3_saturate_filter;

    localparam int SETTLE_CYCLES = 8;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;     // [7:0] pixel_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [7:0] pixel, [19:8] row, [29:20] col
    logic [w3sf_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic                           m_axis_tlast;          // run_last
    logic [0:0]                     m_axis_tuser;          // [0] frame_last
    logic                           i_cfg_we = 1'b0;
    logic [0:0]                     i_cfg_addr = '0;
    logic [w3sf_pkg::CFG_W-1:0]     i_cfg_data = '0;
    int                             mismatches;
    int                             pending;
    int                             send_calm = 0;
    int                             recv_calm = 0;

    always #10 i_clk = ~i_clk;

    window3x3_saturate_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    w3sf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (s_axis_tvalid),
        .i_pix_ready  (s_axis_tready),
        .i_pix_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .i_res_user   (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Pixel mix: a share of foreground, some near-foreground, rest anything below it
    function automatic logic [7:0] draw_pixel(int fg_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < fg_pct) return w3sf_pkg::FG;
        if ($urandom_range(0, 7) == 0) return w3sf_pkg::FG - 8'd1;
        return 8'($urandom_range(0, 254));
    endfunction

    // One pixel beat, after a random gap; returns at the accepting edge
    task automatic send_pixel(input logic [7:0] pix);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(8, 40);
            gap = $urandom_range(0, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic send_random(input int count, input int fg_pct);
        repeat (count) send_pixel(draw_pixel(fg_pct));
    endtask

    // Stop sending, let every result drain, then give the pipe time to go quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input w3sf_pkg::t_cfg_reg idx,
                             input logic [w3sf_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_size(input logic [w3sf_pkg::CFG_W-1:0] w_raw,
                            input logic [w3sf_pkg::CFG_W-1:0] h_raw);
        settle();
        write_reg(w3sf_pkg::CFG_WIDTH, w_raw);
        write_reg(w3sf_pkg::CFG_HEIGHT, h_raw);
    endtask

    // Result side: random stall before each beat, with stall-free stretches
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (recv_calm > 0) begin
                recv_calm--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(8, 40);
                stall = $urandom_range(0, 3);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Stimulus
    initial begin
        logic [7:0] corner_pat [9];
        int         small_items;
        int         w;
        int         h;
        int         count;

        corner_pat = '{w3sf_pkg::FG, 8'd10, 8'd20, 8'd30, 8'd0, 8'd40, 8'd50, 8'd60,
                       w3sf_pkg::FG - 8'd1};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size 640x480: row 0 only, nothing comes out; the write restarts the frame
        send_pixel(w3sf_pkg::FG);
        send_pixel(8'd0);

        // 3x3 frame: foreground in a corner, near-foreground in the opposite corner
        set_size(12'd3, 12'd3);
        for (int k = 0; k < 9; k++) send_pixel(corner_pat[k]);

        // width 1 and height 0 clamp to 2x2; two frames to cross the frame wrap
        set_size(12'd1, 12'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(w3sf_pkg::FG);
        send_pixel(w3sf_pkg::FG - 8'd1);
        send_pixel(8'd1);
        send_pixel(8'd2);
        send_pixel(8'd3);

        // two full frames, then a frame cut short by the next write
        set_size(12'd5, 12'd4);
        send_random(40, 20);
        set_size(12'd7, 12'd6);
        send_random(23, 15);

        // widest setting (clamped to MAX_WIDTH): start of a 1024x2 frame, cut short
        set_size(12'h7FF, 12'd0);
        send_random(16, 3);

        // width bit 11 is dropped, so this is 2 wide; top of a 4095-row frame, cut short
        set_size(12'h802, 12'hFFF);
        send_random(24, 4);

        // many small random sizes, some frames cut short
        small_items = 0;
        while (small_items < 120) begin
            w = $urandom_range(2, 9);
            h = $urandom_range(2, 6);
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, w * h - 1);
            else count = w * h;
            set_size(w[w3sf_pkg::CFG_W-1:0], h[w3sf_pkg::CFG_W-1:0]);
            send_random(count, $urandom_range(0, 40));
            small_items += count;
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
